// ----- rtl/twfs_pkg.sv -----
// Package for the time-window frame smoother.
// Holds the field widths, register indexes, reset values and sequencer states.
// No dependencies; used by time_window_frame_smoother.
`default_nettype none

package twfs_pkg;

  localparam int unsigned FIELD_W          = 16;
  localparam int unsigned SUM_W            = FIELD_W + 1;
  localparam int unsigned DIV_CNT_W        = $clog2(SUM_W + 1);
  localparam int unsigned CFG_IDX_W        = 1;
  localparam int unsigned WINDOW_DEPTH_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME     = 1'd1;

  localparam logic [FIELD_W-1:0] SMOOTH_PERIOD_RST = 16'd500;
  localparam logic [FIELD_W-1:0] MAX_FRAME_RST     = 16'd250;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACC,
    ST_DIV,
    ST_DONE
  } twfs_state_t;

endpackage

`default_nettype wire

// ----- rtl/time_window_frame_smoother.sv -----
// Time-window frame smoother: moving average of frame intervals over a time span.
// Uses twfs_pkg for widths, register indexes, reset values and sequencer states.
//
// Usage: each request on the in_ channel carries one frame interval in ms. It is
// appended to a ring of WINDOW_DEPTH entries, then a sequencer walks the ring from
// the newest entry backwards through the single ring read port, reading each entry in
// a check state and adding it in an accumulate state, until the kept sum reaches
// smooth_period_ms or the valid entries run out. A restoring divider then produces
// the mean, one quotient bit a cycle, and the result request carries the mean and
// the mean capped at max_frame_ms. The next request can be accepted in the same
// cycle as the result becomes valid, not before. in_tready is high only while the
// sequencer is idle. A finished result waits in the output register while the
// next input request is accepted and processed; if the receiver stalls, the
// sequencer holds the following result until the output register frees. The
// configuration port writes a register at each clock edge with cfg_we high; the user
// must write it only while the block is idle; the block itself does not enforce it.
// Synchronous reset empties the window and restores the register defaults; the
// ring contents need no clearing.
`default_nettype none

module time_window_frame_smoother #(
  parameter int unsigned WINDOW_DEPTH = twfs_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [twfs_pkg::FIELD_W-1:0]   in_tdata,    // [15:0] interval_ms
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [2*twfs_pkg::FIELD_W-1:0]      out_tdata,   // [15:0] mean_ms, [31:16] frame_ms
  input  wire logic                           cfg_we,
  input  wire logic [twfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [twfs_pkg::FIELD_W-1:0]   cfg_wdata
);

  localparam int unsigned IW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned FW    = twfs_pkg::FIELD_W;
  localparam int unsigned SW    = twfs_pkg::SUM_W;
  localparam int unsigned DCW   = twfs_pkg::DIV_CNT_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(WINDOW_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(WINDOW_DEPTH);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(SW - 1);

  logic [FW-1:0] ring [WINDOW_DEPTH];
  logic [FW-1:0] rd_data_r;

  twfs_pkg::twfs_state_t state_r, state_nxt;

  logic [FW-1:0]  period_r, max_frame_r;
  logic [IW-1:0]  newest_r, newest_nxt;
  logic [CW-1:0]  kept_cnt_r, kept_cnt_nxt;
  logic [IW-1:0]  walk_slot_r, walk_slot_nxt;
  logic [CW-1:0]  walked_r, walked_nxt;
  logic [CW-1:0]  avail_r, avail_nxt;
  logic [SW-1:0]  sum_r, sum_nxt;
  logic [SW-1:0]  dvd_r, dvd_nxt;
  logic [CW-1:0]  rem_r, rem_nxt;
  logic [DCW-1:0] div_cnt_r, div_cnt_nxt;
  logic           out_tvalid_r, out_tvalid_nxt;
  logic [FW-1:0]  mean_r, mean_nxt;
  logic [FW-1:0]  frame_r, frame_nxt;

  logic           in_acc;
  logic           rd_en;
  logic           walk_go;
  logic           out_free;
  logic [IW-1:0]  next_slot;
  logic [IW-1:0]  prev_slot;
  logic [CW:0]    rem_sh;
  logic           div_ge;
  logic [FW-1:0]  mean_val;

  assign in_tready  = (state_r == twfs_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {frame_r, mean_r};
  assign out_free   = !out_tvalid_r || out_tready;

  assign next_slot = (newest_r == LAST_SLOT) ? '0 : newest_r + 1'b1;
  assign prev_slot = (walk_slot_r == '0) ? LAST_SLOT : walk_slot_r - 1'b1;
  assign walk_go   = (walked_r < avail_r) && (sum_r < {1'b0, period_r});
  assign rd_en     = (state_r == twfs_pkg::ST_CHECK) && walk_go;

  assign rem_sh   = {rem_r, dvd_r[SW-1]};
  assign div_ge   = rem_sh >= {1'b0, walked_r};
  assign mean_val = (walked_r == '0) ? '0 : dvd_r[FW-1:0];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring[next_slot] <= in_tdata;
    end
    if (rd_en) begin
      rd_data_r <= ring[walk_slot_r];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      twfs_pkg::ST_IDLE:  if (in_acc) state_nxt = twfs_pkg::ST_CHECK;
      twfs_pkg::ST_CHECK: state_nxt = walk_go ? twfs_pkg::ST_ACC : twfs_pkg::ST_DIV;
      twfs_pkg::ST_ACC:   state_nxt = twfs_pkg::ST_CHECK;
      twfs_pkg::ST_DIV:   if (div_cnt_r == DIV_LAST) state_nxt = twfs_pkg::ST_DONE;
      twfs_pkg::ST_DONE:  if (out_free) state_nxt = twfs_pkg::ST_IDLE;
      default:            state_nxt = twfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    newest_nxt     = newest_r;
    kept_cnt_nxt   = kept_cnt_r;
    walk_slot_nxt  = walk_slot_r;
    walked_nxt     = walked_r;
    avail_nxt      = avail_r;
    sum_nxt        = sum_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    mean_nxt       = mean_r;
    frame_nxt      = frame_r;
    unique case (state_r)
      twfs_pkg::ST_IDLE: begin
        if (in_acc) begin
          newest_nxt    = next_slot;
          walk_slot_nxt = next_slot;
          walked_nxt    = '0;
          sum_nxt       = '0;
          avail_nxt     = (kept_cnt_r == FULL_CNT) ? kept_cnt_r : kept_cnt_r + 1'b1;
        end
      end
      twfs_pkg::ST_CHECK: begin
        if (!walk_go) begin
          kept_cnt_nxt = walked_r;
          dvd_nxt      = sum_r;
          rem_nxt      = '0;
          div_cnt_nxt  = '0;
        end
      end
      twfs_pkg::ST_ACC: begin
        sum_nxt       = sum_r + SW'(rd_data_r);
        walked_nxt    = walked_r + 1'b1;
        walk_slot_nxt = prev_slot;
      end
      twfs_pkg::ST_DIV: begin
        rem_nxt     = div_ge ? CW'(rem_sh - {1'b0, walked_r}) : CW'(rem_sh);
        dvd_nxt     = {dvd_r[SW-2:0], div_ge};
        div_cnt_nxt = div_cnt_r + 1'b1;
      end
      twfs_pkg::ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          mean_nxt       = mean_val;
          frame_nxt      = (mean_val > max_frame_r) ? max_frame_r : mean_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= twfs_pkg::ST_IDLE;
      newest_r     <= '0;
      kept_cnt_r   <= '0;
      out_tvalid_r <= 1'b0;
      period_r     <= twfs_pkg::SMOOTH_PERIOD_RST;
      max_frame_r  <= twfs_pkg::MAX_FRAME_RST;
    end else begin
      state_r      <= state_nxt;
      newest_r     <= newest_nxt;
      kept_cnt_r   <= kept_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          twfs_pkg::CFG_SMOOTH_PERIOD: period_r    <= cfg_wdata;
          twfs_pkg::CFG_MAX_FRAME:     max_frame_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_slot_r <= walk_slot_nxt;
    walked_r    <= walked_nxt;
    avail_r     <= avail_nxt;
    sum_r       <= sum_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    div_cnt_r   <= div_cnt_nxt;
    mean_r      <= mean_nxt;
    frame_r     <= frame_nxt;
  end

endmodule

`default_nettype wire

// ----- tb/sv/twfs_checker.sv -----
// Checker for the time-window frame smoother: watches the input, result and register ports.
// Predicts each smoothed result from its own copy of the window and compares field by field.
// Depends on twfs_pkg for field widths, register indexes and reset values.
`timescale 1ns / 100ps

module twfs_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [twfs_pkg::FIELD_W-1:0]   in_tdata,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [2*twfs_pkg::FIELD_W-1:0] out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [twfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [twfs_pkg::FIELD_W-1:0]   cfg_wdata,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  checked,
  output int                                  deepest
);

  localparam int unsigned FIELD_W = twfs_pkg::FIELD_W;
  localparam int unsigned DEPTH   = twfs_pkg::WINDOW_DEPTH_DEF;

  typedef struct packed {
    logic [FIELD_W-1:0] frame_ms;
    logic [FIELD_W-1:0] mean_ms;
  } frame_result_t;

  logic [FIELD_W-1:0] interval_hist [DEPTH];
  logic [5:0]         newest_slot;
  logic [6:0]         kept_count;
  logic [FIELD_W-1:0] period_ms;
  logic [FIELD_W-1:0] cap_ms;

  frame_result_t expected_frames[$];
  int            errors = 0;
  int            n_checked = 0;
  int            max_kept = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    errors++;
  endtask

  function automatic frame_result_t smooth_interval(input logic [FIELD_W-1:0] iv);
    frame_result_t r;
    int unsigned   avail;
    int unsigned   walked;
    int unsigned   sum;
    int unsigned   slot;
    int unsigned   mean;
    newest_slot = newest_slot + 6'd1;
    interval_hist[newest_slot] = iv;
    avail = kept_count + 1;
    if (avail > DEPTH) begin
      avail = DEPTH;
    end
    slot   = newest_slot;
    walked = 0;
    sum    = 0;
    while (walked < avail && sum < period_ms) begin
      sum += interval_hist[slot];
      walked++;
      slot = (slot == 0) ? DEPTH - 1 : slot - 1;
    end
    kept_count = walked[6:0];
    if (walked > max_kept) begin
      max_kept = walked;
    end
    mean       = (walked == 0) ? 0 : sum / walked;
    r.mean_ms  = mean[FIELD_W-1:0];
    r.frame_ms = (r.mean_ms > cap_ms) ? cap_ms : r.mean_ms;
    return r;
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    frame_result_t fresh;
    if (!rst_n) begin
      newest_slot = '0;
      kept_count  = '0;
      period_ms   = twfs_pkg::SMOOTH_PERIOD_RST;
      cap_ms      = twfs_pkg::MAX_FRAME_RST;
      expected_frames.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          twfs_pkg::CFG_SMOOTH_PERIOD: begin
            period_ms = cfg_wdata;
          end
          twfs_pkg::CFG_MAX_FRAME: begin
            cap_ms = cfg_wdata;
          end
          default: begin
          end
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_frames.size() == 0) begin
          report_mismatch($sformatf("result with no request pending, tdata=%h", out_tdata));
        end else begin
          want = expected_frames.pop_front();
          n_checked++;
          if (got.mean_ms !== want.mean_ms) begin
            report_mismatch($sformatf("mean_ms got %0d want %0d", got.mean_ms, want.mean_ms));
          end
          if (got.frame_ms !== want.frame_ms) begin
            report_mismatch($sformatf("frame_ms got %0d want %0d",
                                      got.frame_ms, want.frame_ms));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        fresh = smooth_interval(in_tdata);
        expected_frames = {expected_frames, fresh};
      end
    end
    fail_count <= errors;
    pending    <= expected_frames.size();
    checked    <= n_checked;
    deepest    <= max_kept;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the testbench for time_window_frame_smoother: clock, reset, stimulus and verdict.
// Drives directed and random frame intervals across several register settings.
// Depends on twfs_pkg, the block itself and twfs_checker.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned FIELD_W   = twfs_pkg::FIELD_W;
  localparam int unsigned CFG_IDX_W = twfs_pkg::CFG_IDX_W;
  localparam int unsigned DEPTH     = twfs_pkg::WINDOW_DEPTH_DEF;
  localparam int          N_PHASES = 11;
  localparam int          PHASE_ITEMS = 105;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [FIELD_W-1:0]     in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [2*FIELD_W-1:0]   out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [FIELD_W-1:0]     cfg_wdata = '0;

  int  fail_count;
  int  pending;
  int  checked;
  int  deepest;
  int  sent = 0;
  int  stall_left = 0;
  bit  tx_gaps = 1'b1;
  bit  rx_stalls = 1'b1;

  time_window_frame_smoother dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  twfs_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked),
    .deepest   (deepest)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 4);
    end else if (r < 98) begin
      return $urandom_range(5, 30);
    end
    return $urandom_range(100, 300);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_reg();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return FIELD_W'($urandom_range(1, 3000));
      default: return FIELD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pick_interval(input int mode);
    int r;
    case (mode)
      0: return FIELD_W'($urandom_range(0, 40));
      1: return FIELD_W'($urandom_range(5, 200));
      2: return FIELD_W'($urandom_range(0, 65535));
      default: begin
        r = $urandom_range(0, 19);
        if (r < 2) begin
          return FIELD_W'($urandom_range(0, 65535));
        end else if (r < 4) begin
          return '0;
        end else if (r == 4) begin
          return '1;
        end
        return FIELD_W'($urandom_range(5, 200));
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_interval(input logic [FIELD_W-1:0] iv);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= iv;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [FIELD_W-1:0] period, input logic [FIELD_W-1:0] cap);
    drain();
    write_reg(twfs_pkg::CFG_SMOOTH_PERIOD, period);
    write_reg(twfs_pkg::CFG_MAX_FRAME, cap);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int mode;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings: field extremes, cap boundary, a window filling up.
    push_interval(16'd0);
    push_interval(16'd65535);
    push_interval(16'd1);
    push_interval(16'd249);
    push_interval(16'd250);
    push_interval(16'd251);
    push_interval(16'd500);
    push_interval(16'd499);
    repeat (5) push_interval(16'd100);
    push_interval(16'd65535);

    // A period of zero keeps nothing, not even the newest interval.
    set_window(16'd0, 16'd250);
    push_interval(16'd300);
    push_interval(16'd65535);
    push_interval(16'd0);

    // A cap of zero, with the largest period and the largest intervals.
    set_window(16'd65535, 16'd0);
    push_interval(16'd65535);
    push_interval(16'd65535);
    push_interval(16'd7);

    // Zero intervals still count as kept entries.
    set_window(16'd1, 16'd65535);
    repeat (3) push_interval(16'd0);
    push_interval(16'd1);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          set_window(16'd65535, 16'd65535);
          mode = 0;
        end
        1: begin
          set_window(16'd1, 16'd1);
          mode = 2;
        end
        2: begin
          set_window(16'd0, 16'd0);
          mode = 2;
        end
        3: begin
          set_window(twfs_pkg::SMOOTH_PERIOD_RST, twfs_pkg::MAX_FRAME_RST);
          mode = 3;
        end
        default: begin
          set_window(pick_reg(), pick_reg());
          mode = $urandom_range(0, 3);
        end
      endcase
      tx_gaps   = (ph % 3 != 1);
      rx_stalls = (ph % 4 != 2);
      repeat (PHASE_ITEMS) push_interval(pick_interval(mode));
    end

    drain();
    repeat (2 * DEPTH + 40) @(posedge clk);

    $display("Sent %0d intervals over %0d register settings, checked %0d results",
             sent, N_PHASES + 4, checked);
    $display("Deepest window kept: %0d entries", deepest);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- time_window_frame_smoother.f -----
rtl/twfs_pkg.sv
rtl/time_window_frame_smoother.sv
tb/sv/twfs_checker.sv
tb/sv/tb_top.sv
